// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/frc_pkg.sv -----
// ----------------------------------------------------------------------------
// frc_pkg
// Types, codes and helpers for the framed response checker.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'h55;
    localparam logic [15:0] GOOD_WORD = 16'h9000;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // result codes
    localparam logic [2:0] RES_OK      = 3'd0;
    localparam logic [2:0] RES_CRC     = 3'd1;
    localparam logic [2:0] RES_LEN     = 3'd2;
    localparam logic [2:0] RES_WORD    = 3'd3;
    localparam logic [2:0] RES_TIMEOUT = 3'd4;

    // configuration register indexes
    localparam int         CFG_ADDR_W = 2;
    localparam int         CFG_DATA_W = 64;
    localparam logic [1:0] REG_EXP_LEN   = 2'd0;
    localparam logic [1:0] REG_KEY_UPPER = 2'd1;
    localparam logic [1:0] REG_KEY_LOWER = 2'd2;
    localparam logic [1:0] REG_MASK_EN   = 2'd3;

    typedef struct packed {
        logic [5:0]  expected_length;
        logic [63:0] key_upper;
        logic [63:0] key_lower;
        logic        mask_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        ST_RECV,
        ST_CRC,
        ST_EVAL,
        ST_EMIT,
        ST_READ,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic crc_shift;  // one CRC bit step
        logic eval;       // latch frame verdict
        logic emit;       // load single result into output register
        logic rd;         // read payload buffer
        logic push;       // load payload result into output register
    } dp_cmd_t;

    typedef struct packed {
        logic take_timeout;  // word at input raises a hunt timeout
        logic take_crc;      // word at input is CRC covered
        logic take_end;      // word at input closes the frame
        logic stream;        // verdict is ok with payload to send
        logic last_idx;      // read pointer at final payload byte
        logic out_free;      // output register can load
    } dp_sts_t;

    // key byte at position pos of the repeating 16-byte key, zero if unmasked
    function automatic logic [7:0] key_byte(cfg_t cfg, logic [3:0] pos);
        logic [127:0] key;
        logic [3:0]   r;
        key = {cfg.key_upper, cfg.key_lower};
        r   = 4'd15 - pos;
        return cfg.mask_enable ? key[{r, 3'b000} +: 8] : 8'h00;
    endfunction

endpackage

// ----- src/frc_cfg.sv -----
// ----------------------------------------------------------------------------
// frc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module frc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [frc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output frc_pkg::cfg_t                   cfg
);
    import frc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_EXP_LEN:   cfg_next.expected_length = cfg_wr_data[5:0];
                REG_KEY_UPPER: cfg_next.key_upper       = cfg_wr_data;
                REG_KEY_LOWER: cfg_next.key_lower       = cfg_wr_data;
                REG_MASK_EN:   cfg_next.mask_enable     = cfg_wr_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_length <= 6'd29;
            cfg_reg.key_upper       <= '0;
            cfg_reg.key_lower       <= '0;
            cfg_reg.mask_enable     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/frc_ctrl.sv -----
// ----------------------------------------------------------------------------
// frc_ctrl
// Sequencer: input acceptance, CRC bit steps, verdict and result delivery.
// ----------------------------------------------------------------------------
module frc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  frc_pkg::dp_sts_t  sts,
    output frc_pkg::dp_cmd_t  cmd
);
    import frc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [2:0]  bit_cnt_reg;
    logic [2:0]  bit_cnt_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV: begin
                if (s_tvalid) begin
                    if (sts.take_timeout) begin
                        state_next = ST_EMIT;
                    end else if (sts.take_crc) begin
                        state_next = ST_CRC;
                    end else if (sts.take_end) begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_CRC: begin
                if (bit_cnt_reg == 3'd7) begin
                    state_next = ST_RECV;
                end
            end
            ST_EVAL: begin
                state_next = sts.stream ? ST_READ : ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_RECV;
                end
            end
            ST_READ: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (sts.out_free) begin
                    state_next = sts.last_idx ? ST_RECV : ST_READ;
                end
            end
            default: state_next = ST_RECV;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        bit_cnt_next = 3'd0;
        case (state_reg)
            ST_RECV: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CRC: begin
                cmd.crc_shift = 1'b1;
                bit_cnt_next  = bit_cnt_reg + 3'd1;
            end
            ST_EVAL: cmd.eval = 1'b1;
            ST_EMIT: cmd.emit = sts.out_free;
            ST_READ: cmd.rd   = 1'b1;
            ST_PUSH: cmd.push = sts.out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RECV;
            bit_cnt_reg <= 3'd0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

// ----- src/frc_dp.sv -----
// ----------------------------------------------------------------------------
// frc_dp
// Datapath: frame parser, bit-serial CRC, payload buffer and output register.
// ----------------------------------------------------------------------------
module frc_dp #(
    parameter int MAX_PAYLOAD = 48,
    parameter int POLL_LIMIT  = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        s_tdata,
    input  frc_pkg::cfg_t     cfg,
    input  frc_pkg::dp_cmd_t  cmd,
    output frc_pkg::dp_sts_t  sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // status[2:0], data_byte[10:3], status_word[26:11]
    output logic              m_tlast
);
    import frc_pkg::*;

    localparam int         AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int         PW     = $clog2(POLL_LIMIT + 1);
    localparam logic [6:0] MAXP   = 7'(MAX_PAYLOAD);
    localparam logic [PW-1:0] PLIM = PW'(POLL_LIMIT);

    // parser state
    phase_t        phase_reg,  phase_next;
    logic [PW-1:0] poll_reg,   poll_next;
    logic [5:0]    idx_reg,    idx_next;
    logic [15:0]   len_reg,    len_next;
    logic [15:0]   crc_reg,    crc_next;
    logic [15:0]   rcrc_reg,   rcrc_next;
    logic [15:0]   word_reg,   word_next;

    // result side
    logic [7:0]    mem [0:MAX_PAYLOAD-1];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [2:0]    res_code_reg;
    logic [15:0]   res_sw_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [7:0]    out_data_reg;
    logic [15:0]   out_sw_reg;
    logic          out_last_reg;

    logic [5:0]    eff_len;
    logic [6:0]    len7;
    logic [6:0]    idx7;
    logic [5:0]    idx_inc;
    logic [PW-1:0] poll_inc;
    logic          is_sync;
    logic          timeout_hit;
    logic          in_payload;
    logic          covered;
    logic          frame_end;
    logic [6:0]    sw_pos;
    logic [15:0]   sw_unmasked;
    logic [2:0]    verdict;
    logic [6:0]    rd_pos;
    logic          out_load;

    assign eff_len     = ({1'b0, cfg.expected_length} > MAXP) ? MAXP[5:0] : cfg.expected_length;
    assign len7        = {1'b0, eff_len};
    assign idx7        = {1'b0, idx_reg};
    assign idx_inc     = idx_reg + 6'd1;
    assign poll_inc    = poll_reg + PW'(1);
    assign is_sync     = (s_tdata == SYNC_BYTE);
    assign timeout_hit = (poll_inc >= PLIM);
    assign in_payload  = (idx7 < len7);
    assign covered     = (idx7 < len7 + 7'd2);
    assign frame_end   = ({1'b0, idx_inc} >= len7 + 7'd4);

    // status bytes sit at key positions L and L+1
    assign sw_pos      = len7 + 7'd1;
    assign sw_unmasked = word_reg ^ {key_byte(cfg, len7[3:0]), key_byte(cfg, sw_pos[3:0])};

    always_comb begin
        if (len_reg != {9'd0, len7} + 16'd2) begin
            verdict = RES_LEN;
        end else if (crc_reg != rcrc_reg) begin
            verdict = RES_CRC;
        end else if (sw_unmasked != GOOD_WORD) begin
            verdict = RES_WORD;
        end else begin
            verdict = RES_OK;
        end
    end

    assign rd_pos   = {{(7 - AW){1'b0}}, rd_idx_reg};
    assign out_load = cmd.emit || cmd.push;

    assign sts.take_timeout = (phase_reg == PH_HUNT) && !is_sync && timeout_hit;
    assign sts.take_crc     = (phase_reg == PH_BODY) && covered;
    assign sts.take_end     = (phase_reg == PH_BODY) && frame_end;
    assign sts.stream       = (verdict == RES_OK) && (eff_len != 6'd0);
    assign sts.last_idx     = (rd_pos + 7'd1 == len7);
    assign sts.out_free     = !out_valid_reg || m_tready;

    always_comb begin
        phase_next = phase_reg;
        poll_next  = poll_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        word_next  = word_reg;
        if (cmd.accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (is_sync) begin
                        phase_next = PH_LEN;
                        poll_next  = '0;
                        idx_next   = 6'd0;
                    end else begin
                        poll_next = timeout_hit ? '0 : poll_inc;
                    end
                end
                PH_LEN: begin
                    if (idx_reg == 6'd0) begin
                        len_next = {s_tdata, 8'h00};
                        idx_next = 6'd1;
                    end else begin
                        len_next   = {len_reg[15:8], s_tdata};
                        idx_next   = 6'd0;
                        crc_next   = 16'd0;
                        rcrc_next  = 16'd0;
                        word_next  = 16'd0;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (covered) begin
                        crc_next = crc_reg ^ {s_tdata, 8'h00};
                    end
                    if (in_payload) begin
                        word_next = word_reg;
                    end else if (idx7 == len7) begin
                        word_next = {s_tdata, word_reg[7:0]};
                    end else if (idx7 == len7 + 7'd1) begin
                        word_next = {word_reg[15:8], s_tdata};
                    end else if (idx7 == len7 + 7'd2) begin
                        rcrc_next = {s_tdata, rcrc_reg[7:0]};
                    end else begin
                        rcrc_next = {rcrc_reg[15:8], s_tdata};
                    end
                    idx_next = idx_inc;
                    if (frame_end) begin
                        phase_next = PH_HUNT;
                        poll_next  = '0;
                        idx_next   = 6'd0;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end
        if (cmd.crc_shift) begin
            crc_next = crc_reg[15] ? ({crc_reg[14:0], 1'b0} ^ CRC_POLY)
                                   : {crc_reg[14:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            poll_reg  <= '0;
            idx_reg   <= 6'd0;
            len_reg   <= 16'd0;
            crc_reg   <= 16'd0;
            rcrc_reg  <= 16'd0;
            word_reg  <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            poll_reg  <= poll_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            word_reg  <= word_next;
        end
    end

    // payload buffer, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.accept && (phase_reg == PH_BODY) && in_payload) begin
            mem[idx_reg[AW-1:0]] <= s_tdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && sts.take_timeout) begin
            res_code_reg <= RES_TIMEOUT;
            res_sw_reg   <= 16'd0;
        end else if (cmd.eval) begin
            res_code_reg <= verdict;
            res_sw_reg   <= sw_unmasked;
        end
        if (cmd.eval) begin
            rd_idx_reg <= '0;
        end else if (cmd.push) begin
            rd_idx_reg <= rd_idx_reg + AW'(1);
        end
        if (cmd.emit) begin
            out_status_reg <= res_code_reg;
            out_data_reg   <= 8'h00;
            out_sw_reg     <= res_sw_reg;
            out_last_reg   <= 1'b1;
        end else if (cmd.push) begin
            out_status_reg <= RES_OK;
            out_data_reg   <= rdata_reg ^ key_byte(cfg, rd_pos[3:0]);
            out_sw_reg     <= res_sw_reg;
            out_last_reg   <= sts.last_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_sw_reg, out_data_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/framed_response_checker.sv -----
// ----------------------------------------------------------------------------
// framed_response_checker
// Sync hunt, framed response parse, CRC-16/XMODEM check and payload unmask.
// ----------------------------------------------------------------------------
//  channel  | dir | word carries
//  ---------+-----+---------------------------------------------------------
//  s_       | in  | rx_byte in tdata[7:0]
//  m_       | out | status, data_byte, status_word in tdata; last in tlast
//  cfg_     | in  | register writes: index in cfg_addr, value in cfg_wr_data
//
//  Hunt, length and CRC bytes are taken by the accept alone. Payload and
//  status bytes take the accept plus 8 bit-serial CRC steps.
//  A timeout adds a load step. A frame end adds a verdict step, then a load
//  for a single result or a buffer read and a load per payload result.
//  Reset is synchronous on aresetn low; no clearing pass is run.
//  Input is closed while a result waits to load; a held output word delays it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_response_checker #(
    parameter int MAX_PAYLOAD = 48,
    parameter int POLL_LIMIT  = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // rx_byte[7:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // status[2:0], data_byte[10:3],
                                                       // status_word[26:11]
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [frc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import frc_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    frc_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    frc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frc_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .POLL_LIMIT  (POLL_LIMIT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a result load never overwrites a word still waiting at the output
    `ASSERT_SAME(a_load_free, aclk, aresetn, cmd.emit || cmd.push, !m_tvalid || m_tready)
    // only payload words of a good frame come without tlast
    `ASSERT_SAME(a_mid_ok, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[2:0] == RES_OK)
    // a timeout word blocks input until it is loaded at the output
    `ASSERT_NEXT(a_timeout_hold, aclk, aresetn, s_tvalid && s_tready && sts.take_timeout,
                 !s_tready)

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for framed_response_checker. Builds response frames
// (sync, length, payload, status word, CRC-16/XMODEM), pushes them through the
// byte stream with bursty input and a stalling receiver, and compares every
// result word against a cycle-free predictor of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import frc_pkg::*;

    localparam int PAYLOAD_DEPTH   = 48;
    localparam int POLL_LIMIT      = 4096;
    localparam int SETTLE_CYCLES   = 24;
    localparam int END_CYCLES      = 40;
    localparam int WATCHDOG_CYCLES = 1000;
    localparam int PRINT_LIMIT     = 100;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_byte;
        logic [15:0] status_word;
        logic        last;
    } frame_result_t;

    typedef enum {
        KIND_GOOD,
        KIND_BAD_LEN,
        KIND_BAD_CRC,
        KIND_BAD_WORD,
        KIND_NOISE
    } frame_kind_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;   // rx_byte[7:0]
    logic        m_tvalid;
    logic        m_tready    = 1'b1;
    logic [31:0] m_tdata;               // status[2:0], data_byte[10:3], status_word[26:11]
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    framed_response_checker #(
        .MAX_PAYLOAD (PAYLOAD_DEPTH),
        .POLL_LIMIT  (POLL_LIMIT)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    cfg_t          cfg_shadow;
    phase_t        fp_phase;
    logic [12:0]   fp_polls;
    logic [5:0]    fp_index;
    logic [15:0]   fp_len_field;
    logic [15:0]   fp_crc;
    logic [15:0]   fp_rx_crc;
    logic [15:0]   fp_word;
    logic [7:0]    fp_payload [PAYLOAD_DEPTH];
    frame_result_t pending_results [$];

    int unsigned mismatches      = 0;
    int unsigned idle_cycles     = 0;
    int unsigned burst_left      = 0;
    bit          sender_bursty   = 1'b0;
    bit          receiver_stalls = 1'b0;
    logic [15:0] stall_bits      = 16'hFFFF;
    logic [3:0]  stall_phase     = 4'd0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void reset_predictor();
        cfg_shadow.expected_length = 6'd29;
        cfg_shadow.key_upper       = '0;
        cfg_shadow.key_lower       = '0;
        cfg_shadow.mask_enable     = 1'b0;
        fp_phase     = PH_HUNT;
        fp_polls     = '0;
        fp_index     = '0;
        fp_len_field = '0;
        fp_crc       = '0;
        fp_rx_crc    = '0;
        fp_word      = '0;
        foreach (fp_payload[i]) fp_payload[i] = 8'h00;
    endfunction

    function automatic int unsigned payload_span();
        return (cfg_shadow.expected_length > PAYLOAD_DEPTH) ?
               PAYLOAD_DEPTH : cfg_shadow.expected_length;
    endfunction

    function automatic logic [7:0] mask_key(int unsigned pos);
        logic [127:0] k;
        k = {cfg_shadow.key_upper, cfg_shadow.key_lower};
        if (!cfg_shadow.mask_enable)
            return 8'h00;
        return k[8 * (15 - (pos % 16)) +: 8];
    endfunction

    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [7:0] d,
                                        logic [15:0] w, logic l);
        frame_result_t r;
        r.status      = st;
        r.data_byte   = d;
        r.status_word = w;
        r.last        = l;
        pending_results.push_back(r);
    endfunction

    // advance the predictor by one accepted rx byte
    function automatic void track_rx_byte(logic [7:0] b);
        int unsigned span;
        logic [15:0] sw;
        span = payload_span();
        case (fp_phase)
            PH_HUNT: begin
                if (b == SYNC_BYTE) begin
                    fp_phase = PH_LEN;
                    fp_polls = '0;
                    fp_index = '0;
                end else begin
                    fp_polls = fp_polls + 13'd1;
                    if (fp_polls >= POLL_LIMIT) begin
                        fp_polls = '0;
                        push_result(RES_TIMEOUT, 8'h00, 16'h0000, 1'b1);
                    end
                end
                return;
            end
            PH_LEN: begin
                if (fp_index == 0) begin
                    fp_len_field = {b, 8'h00};
                    fp_index     = 6'd1;
                end else begin
                    fp_len_field[7:0] = b;
                    fp_index  = '0;
                    fp_crc    = '0;
                    fp_rx_crc = '0;
                    fp_word   = '0;
                    fp_phase  = PH_BODY;
                end
                return;
            end
            default: ;
        endcase

        if (fp_index < span) begin
            if (fp_index < PAYLOAD_DEPTH)
                fp_payload[fp_index] = b;
            fp_crc = crc16_step(fp_crc, b);
        end else if (fp_index == span) begin
            fp_word[15:8] = b;
            fp_crc = crc16_step(fp_crc, b);
        end else if (fp_index == span + 1) begin
            fp_word[7:0] = b;
            fp_crc = crc16_step(fp_crc, b);
        end else if (fp_index == span + 2) begin
            fp_rx_crc[15:8] = b;
        end else begin
            fp_rx_crc[7:0] = b;
        end
        fp_index = fp_index + 6'd1;
        if (fp_index < span + 4)
            return;

        // frame complete: verdict in priority order
        sw       = fp_word ^ {mask_key(span), mask_key(span + 1)};
        fp_phase = PH_HUNT;
        fp_polls = '0;
        fp_index = '0;
        if (fp_len_field != span + 2)
            push_result(RES_LEN, 8'h00, sw, 1'b1);
        else if (fp_crc != fp_rx_crc)
            push_result(RES_CRC, 8'h00, sw, 1'b1);
        else if (sw != GOOD_WORD)
            push_result(RES_WORD, 8'h00, sw, 1'b1);
        else if (span == 0)
            push_result(RES_OK, 8'h00, sw, 1'b1);
        else
            for (int i = 0; i < span; i++)
                push_result(RES_OK, fp_payload[i] ^ mask_key(i), sw, i + 1 == span);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
                if (m_tdata[10:3] !== want.data_byte)
                    report_mismatch("data_byte", 32'(m_tdata[10:3]), 32'(want.data_byte));
                if (m_tdata[26:11] !== want.status_word)
                    report_mismatch("status_word", 32'(m_tdata[26:11]),
                                    32'(want.status_word));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // receiver stalls follow a random bit pattern reloaded whenever stall_phase wraps
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 4'd1;
        if (stall_phase == 4'd0)
            stall_bits <= 16'($urandom);
        m_tready <= !receiver_stalls || stall_bits[stall_phase];
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        track_rx_byte(b);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // block idle: results drained plus room for a word still in the CRC shift
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        case (idx)
            REG_EXP_LEN:   cfg_shadow.expected_length = value[5:0];
            REG_KEY_UPPER: cfg_shadow.key_upper       = value;
            REG_KEY_LOWER: cfg_shadow.key_lower       = value;
            REG_MASK_EN:   cfg_shadow.mask_enable     = value[0];
            default: ;
        endcase
    endtask

    function automatic logic [7:0] random_non_sync();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == SYNC_BYTE) ? ~b : b;
    endfunction

    // status word is given unmasked; it is masked here the way the far end would
    task automatic send_frame(input logic [15:0] len_field, input logic [15:0] word,
                              input logic [15:0] crc_flip, input bit extreme_fill);
        int unsigned span;
        logic [7:0]  raw;
        logic [15:0] crc;
        logic [15:0] word_raw;
        span = payload_span();
        crc  = 16'h0000;
        send_byte(SYNC_BYTE);
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        for (int i = 0; i < span; i++) begin
            if (!extreme_fill)
                raw = 8'($urandom);
            else
                case (i % 3)
                    0:       raw = 8'h00;
                    1:       raw = 8'hFF;
                    default: raw = SYNC_BYTE;
                endcase
            crc = crc16_step(crc, raw);
            send_byte(raw);
        end
        word_raw = word ^ {mask_key(span), mask_key(span + 1)};
        crc = crc16_step(crc, word_raw[15:8]);
        crc = crc16_step(crc, word_raw[7:0]);
        crc = crc ^ crc_flip;
        send_byte(word_raw[15:8]);
        send_byte(word_raw[7:0]);
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
    endtask

    task automatic finish_partial_frame();
        while (fp_phase != PH_HUNT) send_byte(8'($urandom));
    endtask

    task automatic random_frame(input bit force_good);
        int unsigned pick;
        frame_kind_t kind;
        logic [15:0] good_len;
        logic [15:0] value;
        good_len = 16'(payload_span() + 2);
        pick     = $urandom_range(0, 9);
        if (force_good || pick < 6) kind = KIND_GOOD;
        else if (pick == 6)         kind = KIND_BAD_LEN;
        else if (pick == 7)         kind = KIND_BAD_CRC;
        else if (pick == 8)         kind = KIND_BAD_WORD;
        else                        kind = KIND_NOISE;
        value = 16'($urandom);
        case (kind)
            KIND_GOOD:
                send_frame(good_len, GOOD_WORD, 16'h0000, 1'b0);
            KIND_BAD_LEN:
                send_frame((value == good_len) ? ~value : value, GOOD_WORD,
                           16'h0000, 1'b0);
            KIND_BAD_CRC:
                send_frame(good_len, GOOD_WORD, (value == 0) ? 16'h0001 : value, 1'b0);
            KIND_BAD_WORD:
                send_frame(good_len, (value == GOOD_WORD) ? ~value : value,
                           16'h0000, 1'b0);
            default: begin
                // line noise, possibly a stray sync that opens a junk frame
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                finish_partial_frame();
            end
        endcase
    endtask

    task automatic run_setting(input logic [5:0] exp_len, input logic [63:0] key_hi,
                               input logic [63:0] key_lo, input logic mask_on,
                               input int frames, input bit idling);
        settle();
        write_reg(REG_EXP_LEN, 64'(exp_len));
        write_reg(REG_KEY_UPPER, key_hi);
        write_reg(REG_KEY_LOWER, key_lo);
        write_reg(REG_MASK_EN, 64'(mask_on));
        sender_bursty   = idling;
        receiver_stalls = idling;
        for (int f = 0; f < frames; f++) begin
            random_frame(f == 0);
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // zero-length payload exercises each verdict and its priority cheaply
    task automatic test_frame_verdicts();
        settle();
        write_reg(REG_EXP_LEN, 64'd0);
        sender_bursty   = 1'b0;
        receiver_stalls = 1'b0;
        send_frame(16'd2, GOOD_WORD, 16'h0000, 1'b0);
        send_frame(16'hFFFF, GOOD_WORD, 16'h0001, 1'b0);   // length beats crc
        send_frame(16'd2, 16'h6A82, 16'h8000, 1'b0);        // crc beats word
        send_frame(16'd2, 16'h0000, 16'h0000, 1'b0);
    endtask

    task automatic test_payload_extremes();
        settle();
        write_reg(REG_EXP_LEN, 64'd3);
        sender_bursty   = 1'b1;
        receiver_stalls = 1'b1;
        send_frame(16'd5, GOOD_WORD, 16'h0000, 1'b1);
    endtask

    task automatic test_poll_timeout();
        sender_bursty   = 1'b0;
        receiver_stalls = 1'b1;
        // one short of the limit, then a sync must clear the count
        repeat (POLL_LIMIT - 1) send_byte(random_non_sync());
        send_frame(16'(payload_span() + 2), GOOD_WORD, 16'h0000, 1'b0);
        sender_bursty = 1'b1;
        repeat (POLL_LIMIT) send_byte(random_non_sync());
        repeat (5) send_byte(random_non_sync());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_setting(6'd48, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1, 1'b1);
        // above the buffer depth: saturates to a full buffer
        run_setting(6'd63, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1, 1'b0);
        run_setting(6'd0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 3, 1'b1);
        run_setting(6'($urandom_range(1, 4)), '1, '1, 1'b1, 5, 1'b1);
        run_setting(6'($urandom_range(1, 4)), {$urandom, $urandom}, {$urandom, $urandom},
                    1'b0, 5, 1'b0);
        run_setting(6'($urandom_range(1, 4)), '0, '0, 1'b1, 3, 1'b1);
        run_setting(6'($urandom_range(1, 4)), {$urandom, $urandom}, {$urandom, $urandom},
                    1'b1, 5, 1'b1);
    endtask

    initial begin
        reset_predictor();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_frame_verdicts();
        test_payload_extremes();
        test_poll_timeout();
        test_random_traffic();

        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/frc_pkg.sv
src/frc_cfg.sv
src/frc_ctrl.sv
src/frc_dp.sv
src/framed_response_checker.sv
tb/testbench.sv
